// ----- design/dmca_pkg.sv -----
// shared types and constants for the direct-mapped cache with aging
// no dependencies; imported by every module of the block
package dmca_pkg;

  // fixed field widths
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int THR_W      = 16;
  localparam int OCC_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // parameter defaults
  localparam int DEF_TABLE_SLOTS = 1024;
  localparam int DEF_AGE_BITS    = 16;

  // occupancy limit reset value and occupancy counter saturation point
  localparam logic [OCC_W-1:0] OCC_RESET = OCC_W'(100);
  localparam logic [OCC_W-1:0] OCC_MAX   = '1;

  // remainder unit: quotient estimate, difference, final correction
  localparam int MOD_STEPS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_THR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_LIMIT   = CFG_IDX_W'(2);

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // request item
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } req_t;

  // result item
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             stored;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic req_load;
    logic mod_step;
    logic mem_rd;
    logic eval;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic mod_done;
  } ctrl_sts_t;

endpackage

// ----- design/dmca_mod.sv -----
// slot index unit: key modulo the slot count
// low key bits for a power-of-two count, else a reciprocal-multiply remainder; uses dmca_pkg
module dmca_mod import dmca_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [KEY_W-1:0]               key_i,
  output logic [$clog2(TABLE_SLOTS)-1:0] idx_o,
  output logic                           done_o
);

  localparam int  IDX_W     = $clog2(TABLE_SLOTS);
  localparam bit  SlotsPow2 = ((1 << IDX_W) == TABLE_SLOTS);

  if (SlotsPow2) begin : g_pow2
    logic [IDX_W-1:0] idx_q;

    // index is simply the low key bits
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        idx_q <= '0;
      end else if (load_i) begin
        idx_q <= key_i[IDX_W-1:0];
      end
    end

    assign idx_o  = idx_q;
    assign done_o = 1'b1;
  end else begin : g_div
    localparam int               CntW   = $clog2(MOD_STEPS + 1);
    localparam int               MUL_W  = KEY_W + 1;
    localparam int               PROD_W = KEY_W + MUL_W;
    localparam int               QSH    = KEY_W + IDX_W;
    localparam logic [MUL_W-1:0] Recip  = MUL_W'((64'd1 << QSH) / 64'(TABLE_SLOTS));
    localparam logic [KEY_W-1:0] SlotsK = KEY_W'(TABLE_SLOTS);
    localparam logic [IDX_W:0]   SlotsW = (IDX_W+1)'(TABLE_SLOTS);

    logic [KEY_W-1:0]  key_q;
    logic [KEY_W-1:0]  quot_q;
    logic [IDX_W:0]    diff_q;
    logic [IDX_W-1:0]  rem_q;
    logic [CntW-1:0]   cnt_q;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  diff_full;

    // quotient estimate is low by at most one, so the difference is below twice the count
    always_comb begin
      prod      = PROD_W'(key_q) * PROD_W'(Recip);
      diff_full = key_q - quot_q * SlotsK;
    end

    // three-stage pipeline, all stages valid after three steps
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_q  <= '0;
        quot_q <= '0;
        diff_q <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
      end else if (load_i) begin
        key_q <= key_i;
        cnt_q <= '0;
      end else if (step_i) begin
        quot_q <= KEY_W'(prod >> QSH);
        diff_q <= diff_full[IDX_W:0];
        rem_q  <= (diff_q >= SlotsW) ? IDX_W'(diff_q - SlotsW) : diff_q[IDX_W-1:0];
        cnt_q  <= cnt_q + CntW'(1);
      end
    end

    assign idx_o  = rem_q;
    assign done_o = (cnt_q == CntW'(MOD_STEPS));
  end

endmodule

// ----- design/dmca_dp.sv -----
// datapath: configuration registers, request register, slot memory,
// occupancy counter, clearing counter and result register; uses dmca_pkg, dmca_mod
module dmca_dp import dmca_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_sts_t             sts_o,
  input  req_t                  in_data_i,
  output rsp_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int ROW_W = KEY_W + VAL_W + AGE_BITS;
  localparam int CMP_W = 32;

  logic [THR_W-1:0]    replace_thr_q;
  logic [THR_W-1:0]    refresh_thr_q;
  logic [OCC_W-1:0]    occ_limit_q;
  logic [OCC_W-1:0]    occ_q;
  req_t                req_q;
  rsp_t                out_q;
  logic [IDX_W-1:0]    idx;
  logic                mod_done;
  logic [IDX_W-1:0]    clr_cnt_q;
  logic [ROW_W-1:0]    mem_q [TABLE_SLOTS];
  logic [ROW_W-1:0]    rd_q;
  logic [ROW_W-1:0]    new_row;
  logic [ROW_W-1:0]    wr_row;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_en;
  logic [KEY_W-1:0]    row_key;
  logic [VAL_W-1:0]    row_val;
  logic [AGE_BITS-1:0] row_age;
  logic [CMP_W-1:0]    age_ext;
  logic                key_match;
  logic                do_store;
  logic                occ_inc;
  rsp_t                rsp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_thr_q <= '0;
      refresh_thr_q <= '0;
      occ_limit_q   <= OCC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REPLACE_THR: replace_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_REFRESH_THR: refresh_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_OCC_LIMIT:   occ_limit_q   <= cfg_wdata_i[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= in_data_i;
    end
  end

  // slot index
  dmca_mod #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.req_load),
    .step_i (cmd_i.mod_step),
    .key_i  (in_data_i.lookup_key),
    .idx_o  (idx),
    .done_o (mod_done)
  );

  // clearing counter walks the memory once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + IDX_W'(1);
    end
  end

  // slot evaluation from the registered row
  always_comb begin
    row_key   = rd_q[ROW_W-1 -: KEY_W];
    row_val   = rd_q[AGE_BITS +: VAL_W];
    row_age   = rd_q[AGE_BITS-1:0];
    age_ext   = CMP_W'(row_age);
    key_match = (row_key == req_q.lookup_key);
    do_store  = 1'b0;
    occ_inc   = 1'b0;
    new_row   = rd_q;
    rsp       = '0;
    if (req_q.op == OP_LOOKUP) begin
      if (key_match) begin
        rsp.hit        = 1'b1;
        rsp.read_value = row_val;
        if (age_ext > CMP_W'(refresh_thr_q)) begin
          new_row[AGE_BITS-1:0] = '0;
        end
      end else if (row_age != '1) begin
        new_row[AGE_BITS-1:0] = row_age + AGE_BITS'(1);
      end
    end else begin
      do_store = (occ_q <= occ_limit_q) && !key_match &&
                 (age_ext > CMP_W'(replace_thr_q));
      if (do_store) begin
        new_row    = {req_q.lookup_key, req_q.write_value, {AGE_BITS{1'b0}}};
        rsp.stored = 1'b1;
        occ_inc    = (row_key == '0) && (occ_q != OCC_MAX);
      end
    end
  end

  // occupancy counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.eval && occ_inc) begin
      occ_q <= occ_q + OCC_W'(1);
    end
  end

  // write port: clearing pass or slot update
  assign wr_en   = cmd_i.clr_wr || cmd_i.eval;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : idx;
  assign wr_row  = cmd_i.clr_wr ? '0 : new_row;

  // slot memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[idx];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      out_q <= rsp;
    end
  end

  assign out_data_o     = out_q;
  assign sts_o.mod_done = mod_done;
  assign sts_o.clr_last = (clr_cnt_q == IDX_W'(TABLE_SLOTS - 1));

endmodule

// ----- design/dmca_ctrl.sv -----
// controller: clearing pass, request sequencing and output valid
// drives dmca_dp through ctrl_cmd_t; uses dmca_pkg
module dmca_ctrl import dmca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_EVAL
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // commands per state
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr   = 1'b1;
      ST_IDLE:  cmd_o.req_load = in_valid_i;
      ST_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.mem_rd = 1'b1;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      ST_EVAL:  cmd_o.eval     = out_free;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (sts_i.mod_done) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result register is never overwritten while its item waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while stalled");

  // an accepted item goes on to the index step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MOD))
    else $error("accepted item not sequenced");

  // index ready issues the read and moves to evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD && sts_i.mod_done) |=> (state_q == ST_EVAL))
    else $error("read not followed by evaluation");

  // clearing ends after the last slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clr_last) |=> (state_q == ST_IDLE && !out_valid_q))
    else $error("clearing pass did not end");

endmodule

// ----- design/direct_mapped_cache_with_aging.sv -----
// Direct-mapped key/value cache with age-based replacement.
// Input channel (in_valid_i/in_ready_o/in_data_i): one request item, a lookup
// or an insert. Output channel (out_valid_o/out_ready_i/out_data_o): exactly
// one result item per request, in request order.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once
// (0 replace threshold, 1 refresh threshold, 2 occupancy limit); write only
// while no request is in flight.
// Reset: the slot memory is cleared one slot per cycle, TABLE_SLOTS cycles,
// during which in_ready_o stays low; config writes are taken throughout.
// Sequence: when TABLE_SLOTS is a power of two, an item goes through accept,
// registered memory read and read-modify-write; otherwise the slot index comes
// from a remainder unit (reciprocal multiply, difference, one correction)
// whose steps run between the accept and the registered memory read.
// The result sits in an output register: the next item is accepted while it
// waits, and that item stalls before its memory update until the receiver
// takes the previous result.
// Depends on dmca_pkg, dmca_ctrl, dmca_dp, dmca_mod.
module direct_mapped_cache_with_aging import dmca_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsp_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencing
  dmca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and slot logic
  dmca_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

// ----- sim/tb_direct_mapped_cache_with_aging.sv -----
// testbench for direct_mapped_cache_with_aging: a directed table and random request phases
// over several register settings and idling patterns
// depends on dmca_pkg and the block's RTL; self-contained otherwise
module tb_direct_mapped_cache_with_aging;
  import dmca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS  = DEF_TABLE_SLOTS;
  localparam int AGE_W  = DEF_AGE_BITS;
  localparam logic [AGE_W-1:0] AGE_SAT = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  localparam int  DRAIN_CYCLES  = 20;
  localparam int  HOLD_CYCLES   = 200;
  localparam int  MAX_PRINTED   = 40;
  localparam real TIMEOUT_NS    = 20_000_000.0;

  // row source of the expected result
  localparam logic EXP_PRED  = 1'b0;
  localparam logic EXP_FIXED = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             src;
    logic             hit;
    logic [VAL_W-1:0] rd;
    logic             stored;
  } stim_row_t;

  // directed rows under reset settings (replace 0, refresh 0, limit 100)
  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // key zero lookup hits the empty slot
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, EXP_FIXED, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, EXP_FIXED, 1'b0, 32'h0000_0000, 1'b0},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_FIXED, 1'b0, 32'h0000_0000, 1'b1},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, EXP_FIXED, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // same key already held
    '{OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, EXP_FIXED, 1'b0, 32'h0000_0000, 1'b0},
    // slot age not above replace threshold
    '{OP_INSERT, 32'h0000_0005, 32'hA5A5_A5A5, EXP_FIXED, 1'b0, 32'h0000_0000, 1'b0},
    // key zero insert into an empty slot
    '{OP_INSERT, 32'h0000_0000, 32'h1234_5678, EXP_FIXED, 1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0405, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_INSERT, 32'h0000_0005, 32'hA5A5_A5A5, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0405, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    // replace a held key, count unchanged
    '{OP_INSERT, 32'h0000_0405, 32'h5A5A_5A5A, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0405, 32'h0000_0000, EXP_FIXED, 1'b1, 32'h5A5A_5A5A, 1'b0},
    '{OP_LOOKUP, 32'h0000_0805, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    // hit on an aged slot clears its age
    '{OP_LOOKUP, 32'h0000_0405, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0805, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0400, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_INSERT, 32'h0000_0400, 32'hDEAD_BEEF, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0C00, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    // key zero insert over an aged slot leaves it looking empty
    '{OP_INSERT, 32'h0000_0000, 32'h1357_9BDF, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_LOOKUP, 32'h0000_0400, 32'h0000_0000, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0},
    '{OP_INSERT, 32'h0000_0400, 32'h0000_0001, EXP_PRED,  1'b0, 32'h0000_0000, 1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  req_t                  in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  rsp_t                  out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // cache image and registers as the predictor sees them
  logic [KEY_W-1:0] slot_key_m [SLOTS];
  logic [VAL_W-1:0] slot_val_m [SLOTS];
  logic [AGE_W-1:0] slot_age_m [SLOTS];
  logic [OCC_W-1:0] occ_count;
  logic [THR_W-1:0] replace_thr;
  logic [THR_W-1:0] refresh_thr;
  logic [OCC_W-1:0] occ_limit;

  rsp_t predicted_rsp_q [$];

  int err_count;
  int items_sent;
  int results_checked;
  int hits_seen;
  int stores_seen;
  int send_idle_pct;
  int stall_pct;
  int hold_req;

  direct_mapped_cache_with_aging #(
    .TABLE_SLOTS (SLOTS),
    .AGE_BITS    (AGE_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still outstanding", predicted_rsp_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic cache_image_reset();
    for (int i = 0; i < SLOTS; i++) begin
      slot_key_m[i] = '0;
      slot_val_m[i] = '0;
      slot_age_m[i] = '0;
    end
    occ_count   = '0;
    replace_thr = '0;
    refresh_thr = '0;
    occ_limit   = OCC_RESET;
  endtask

  // one request against the cache image, returns the result it must produce
  function automatic rsp_t predict_cache_access(input req_t r);
    rsp_t        res;
    int unsigned idx;
    res = '0;
    idx = r.lookup_key % SLOTS;
    if (r.op == OP_LOOKUP) begin
      if (slot_key_m[idx] == r.lookup_key) begin
        res.hit        = 1'b1;
        res.read_value = slot_val_m[idx];
        if (slot_age_m[idx] > refresh_thr) slot_age_m[idx] = '0;
      end else if (slot_age_m[idx] != AGE_SAT) begin
        slot_age_m[idx] = slot_age_m[idx] + 1'b1;
      end
    end else if (occ_count <= occ_limit && slot_key_m[idx] != r.lookup_key &&
                 slot_age_m[idx] > replace_thr) begin
      if (slot_key_m[idx] == '0 && occ_count != OCC_MAX) occ_count = occ_count + 1'b1;
      slot_key_m[idx] = r.lookup_key;
      slot_val_m[idx] = r.write_value;
      slot_age_m[idx] = '0;
      res.stored      = 1'b1;
    end
    return res;
  endfunction

  // mostly a few hot slots and tags so hits and replacements happen often
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned slot;
    int unsigned tag;
    r.op          = ($urandom_range(99) < 40) ? OP_INSERT : OP_LOOKUP;
    r.write_value = $urandom();
    pick = $urandom_range(99);
    slot = ($urandom_range(1) == 0) ? $urandom_range(3) : SLOTS - 1 - $urandom_range(3);
    tag  = ($urandom_range(9) == 0) ? 32'h003F_FFFF : $urandom_range(3);
    if (pick < 25) r.lookup_key = slot_key_m[slot];
    else if (pick < 85) r.lookup_key = (tag << 10) | slot;
    else r.lookup_key = $urandom();
    return r;
  endfunction

  // predict, then offer the item until it is taken
  task automatic send_item(input req_t r, input logic src, input rsp_t fixed_rsp);
    rsp_t pred;
    pred = predict_cache_access(r);
    predicted_rsp_q.push_back((src == EXP_FIXED) ? fixed_rsp : pred);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_REPLACE_THR: replace_thr = data;
      CFG_REFRESH_THR: refresh_thr = data;
      CFG_OCC_LIMIT:   occ_limit   = data[OCC_W-1:0];
      default: ;
    endcase
  endtask

  // all three registers plus a write to the unused index, block idle
  task automatic apply_config(input logic [CFG_DATA_W-1:0] rep,
                              input logic [CFG_DATA_W-1:0] refr,
                              input logic [CFG_DATA_W-1:0] lim);
    write_reg(CFG_REPLACE_THR, rep);
    write_reg(CFG_REFRESH_THR, refr);
    write_reg(CFG_OCC_LIMIT, lim);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] rep,
                           input logic [CFG_DATA_W-1:0] refr,
                           input logic [CFG_DATA_W-1:0] lim,
                           input int s_pct, input int r_pct, input int hold, input int n);
    apply_config(rep, refr, lim);
    send_idle_pct = s_pct;
    stall_pct     = r_pct;
    hold_req      = hold;
    repeat (n) send_item(random_request(), EXP_PRED, '0);
    wait_drain();
  endtask

  // result side: check the oldest prediction, then pick next ready
  initial begin
    int hold_left;
    rsp_t want;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (out_data_o.hit) hits_seen++;
        if (out_data_o.stored) stores_seen++;
        if (predicted_rsp_q.size() == 0) begin
          report_mismatch($sformatf("result %p with nothing outstanding", out_data_o));
        end else begin
          want = predicted_rsp_q.pop_front();
          if (out_data_o.hit !== want.hit)
            report_mismatch($sformatf("hit got %b want %b", out_data_o.hit, want.hit));
          if (out_data_o.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %h want %h",
                                      out_data_o.read_value, want.read_value));
          if (out_data_o.stored !== want.stored)
            report_mismatch($sformatf("stored got %b want %b",
                                      out_data_o.stored, want.stored));
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // stimulus
  initial begin
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    results_checked = 0;
    hits_seen     = 0;
    stores_seen   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    cache_image_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table under reset settings
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(req_t'{DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].value},
                DIRECTED_ROWS[i].src,
                rsp_t'{DIRECTED_ROWS[i].hit, DIRECTED_ROWS[i].rd, DIRECTED_ROWS[i].stored});
    end
    wait_drain();

    // random phases over register settings and idling patterns
    run_phase(16'd0, 16'd0, 16'd100, 0, 0, 0, 120);
    run_phase(16'd1, 16'd0, 16'hFFFF, 49, 0, 0, 120);
    run_phase(16'd0, 16'd3, 16'd1023, 0, 49, 0, 120);
    run_phase(16'd2, 16'd1, 16'd0, 38, 38, 0, 100);
    run_phase(16'hFFFF, 16'hFFFF, 16'd1024, 38, 38, 0, 100);
    run_phase(16'd0, 16'd0, 16'd500, 0, 0, HOLD_CYCLES, 150);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run: %0d requests, %0d results (%0d hits, %0d stores) over six random settings",
             items_sent, results_checked, hits_seen, stores_seen);
    $display("run: directed corner rows, idle and stall mixes, one long receiver hold");
    if (err_count == 0 && predicted_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
